/* design/circular_kmismatch_sbndm_matcher_assert.svh */
// Assertion macros for the circular k-mismatch matcher.
// Both macros expect clk_i and rst_ni in the scope of the use.
`ifndef CIRCULAR_KMISMATCH_SBNDM_MATCHER_ASSERT_SVH
`define CIRCULAR_KMISMATCH_SBNDM_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CKSM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cksm: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CKSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cksm: next-cycle check failed");

`endif

/* design/cksm_pkg.sv */
// ----------------------------------------------------------------------------
// cksm_pkg
// Shared constants, register codes and controller state type of the
// circular k-mismatch matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package cksm_pkg;

  localparam int WORD_BITS    = 64;
  localparam int WINDOW_DEPTH = 128;
  localparam int COUNT_BITS   = 32;
  localparam int TABLE_DEPTH  = 256;
  localparam int PAT_DEPTH    = 64;

  localparam int LEN_W  = 6;
  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int POS_W  = 32;
  localparam int ERR_W  = LEN_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH_LIMIT = 2'd1;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PRMW = 8'b0000_0010,
    S_FTXT = 8'b0000_0100,
    S_FTBL = 8'b0000_1000,
    S_FUPD = 8'b0001_0000,
    S_VRD  = 8'b0010_0000,
    S_VCMP = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

/* design/cksm_ram.sv */
// ----------------------------------------------------------------------------
// cksm_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cksm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/circular_kmismatch_sbndm_matcher.sv */
// ----------------------------------------------------------------------------
// circular_kmismatch_sbndm_matcher
// Streaming circular string matcher with up to k mismatches, built on a
// backward bit-parallel filter and an exact rotation check.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A pattern write passes through a
// read-modify-write state, except at index 0, which stays idle and clears
// the incidence table through its valid bits. A text byte that closes no
// window goes straight to the result step. A byte that closes a window runs
// the filter over j <= m window bytes, each as a text RAM read, then an
// incidence RAM read, then an update, and if the filter passes, the rotation
// check reads and compares one byte pair at a time. The pattern store, the
// incidence table and the text window sit in three RAMs with registered reads.
// No clearing pass runs after reset. A result item appears when a window
// matches or on the last byte of a text, and it waits in an output register
// so the next item can be taken while it is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_kmismatch_sbndm_matcher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [5:0] pattern_index, [13:6] data_byte
  input  wire logic        s_axis_tuser,  // req_type
  input  wire logic        s_axis_tlast,  // end_of_text
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [31:0] window_start, [63:32] occurrence_count
  output logic             m_axis_tuser,  // matched
  output logic             m_axis_tlast,  // text_done
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i
);

  localparam int WB    = cksm_pkg::WORD_BITS;
  localparam int LEN_W = cksm_pkg::LEN_W;
  localparam int PTR_W = cksm_pkg::PTR_W;
  localparam int POS_W = cksm_pkg::POS_W;
  localparam int ERR_W = cksm_pkg::ERR_W;
  localparam int CNT_W = cksm_pkg::COUNT_BITS;

  cksm_pkg::state_e state_q, state_d;

  logic [LEN_W-1:0] len_q, len_d, lim_q, lim_d;
  logic [PTR_W-1:0] wp_q, wp_d, wend_q, wend_d;
  logic [POS_W-1:0] tpos_q, tpos_d, nws_q, nws_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             eot_q, eot_d, close_q, close_d, hit_q, hit_d;
  logic [7:0]       byte_q, byte_d;
  logic [LEN_W-1:0] pidx_q, pidx_d;
  logic             vbit_q, vbit_d;
  logic [cksm_pkg::TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [LEN_W-1:0] j_q, j_d, r_q, r_d, t_q, t_d, p_q, p_d;
  logic [ERR_W-1:0] e_q, e_d, diff_q, diff_d;
  logic [WB-1:0]    d_q, d_d;

  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_start_q, out_start_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic             out_match_q, out_match_d, out_done_q, out_done_d;

  // Memory ports.
  logic             txt_we, pat_we, tbl_we;
  logic [PTR_W-1:0] txt_raddr;
  logic [7:0]       txt_rdata, pat_rdata, tbl_raddr, tbl_waddr;
  logic [WB-1:0]    tbl_wdata, tbl_rdata;

  // Working values.
  logic [LEN_W-1:0] m_len;
  logic [ERR_W-1:0] kp1;
  logic [WB-1:0]    init_vec, d_sh, tbl_word;
  logic             in_acc, close_now, res_need, slot_free, mism;
  logic [LEN_W-1:0] j_n;
  logic [ERR_W-1:0] e_n, diff_n;
  logic [CNT_W-1:0] cnt_n;

  // A pattern length of zero behaves as one.
  assign m_len    = (len_q == '0) ? LEN_W'(1) : len_q;
  assign kp1      = {1'b0, lim_q} + ERR_W'(1);
  assign init_vec = {WB{1'b1}} >> (LEN_W'(WB - 1) - m_len);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign close_now = (tpos_q == nws_q + POS_W'(m_len) - POS_W'(1));
  assign res_need  = hit_q || eot_q;
  assign slot_free = !out_valid_q || m_axis_tready;
  assign tbl_word  = tbl_rdata & {WB{vbit_q}};
  assign d_sh      = (d_q >> 1) & tbl_word;
  assign mism      = (txt_rdata != pat_rdata);
  assign diff_n    = diff_q + ERR_W'(mism);
  assign j_n       = j_q + LEN_W'(1);
  assign e_n       = (d_sh == '0) ? e_q + ERR_W'(1) : e_q;
  assign cnt_n     = (hit_q && (total_q != {CNT_W{1'b1}})) ? total_q + CNT_W'(1) : total_q;

  assign s_axis_tready = (state_q == cksm_pkg::S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cnt_q, out_start_q};
  assign m_axis_tuser  = out_match_q;
  assign m_axis_tlast  = out_done_q;

  // Memory write and read controls.
  assign txt_we    = in_acc && (s_axis_tuser == cksm_pkg::REQ_TEXT);
  assign pat_we    = in_acc && (s_axis_tuser == cksm_pkg::REQ_PATTERN);
  assign txt_raddr = (state_q == cksm_pkg::S_VRD)
                   ? wend_q - PTR_W'(m_len) + PTR_W'(1) + PTR_W'(t_q)
                   : wend_q - PTR_W'(j_q);
  assign tbl_raddr = (state_q == cksm_pkg::S_FTBL) ? txt_rdata : s_axis_tdata[13:6];

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = s_axis_tdata[13:6];
    tbl_wdata = WB'(1);
    if (pat_we && (s_axis_tdata[5:0] == '0)) begin
      tbl_we = 1'b1;
    end else if (state_q == cksm_pkg::S_PRMW) begin
      tbl_we    = 1'b1;
      tbl_waddr = byte_q;
      tbl_wdata = tbl_word | (WB'(1) << pidx_q);
    end
  end

  cksm_ram #(.WIDTH(8), .DEPTH(cksm_pkg::WINDOW_DEPTH)) u_text (
    .clk_i  (clk_i),
    .we_i   (txt_we),
    .waddr_i(wp_q),
    .wdata_i(s_axis_tdata[13:6]),
    .raddr_i(txt_raddr),
    .rdata_o(txt_rdata)
  );

  cksm_ram #(.WIDTH(8), .DEPTH(cksm_pkg::PAT_DEPTH)) u_pattern (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(s_axis_tdata[5:0]),
    .wdata_i(s_axis_tdata[13:6]),
    .raddr_i(p_q),
    .rdata_o(pat_rdata)
  );

  cksm_ram #(.WIDTH(WB), .DEPTH(cksm_pkg::TABLE_DEPTH)) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  // Controller: pattern update, backward filter, rotation check, result.
  always_comb begin
    state_d = state_q;
    len_d = len_q;   lim_d = lim_q;
    wp_d = wp_q;     wend_d = wend_q;
    tpos_d = tpos_q; nws_d = nws_q; total_d = total_q;
    eot_d = eot_q;   close_d = close_q; hit_d = hit_q;
    byte_d = byte_q; pidx_d = pidx_q; vbit_d = vbit_q;
    valid_d = valid_q;
    j_d = j_q; r_d = r_q; t_d = t_q; p_d = p_q;
    e_d = e_q; diff_d = diff_q; d_d = d_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_start_d = out_start_q; out_cnt_d = out_cnt_q;
    out_match_d = out_match_q; out_done_d = out_done_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        cksm_pkg::REG_PATTERN_LENGTH: len_d = cfg_data_i;
        cksm_pkg::REG_MISMATCH_LIMIT: lim_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      cksm_pkg::S_IDLE: begin
        if (in_acc) begin
          byte_d = s_axis_tdata[13:6];
          pidx_d = s_axis_tdata[5:0];
          if (s_axis_tuser == cksm_pkg::REQ_PATTERN) begin
            vbit_d = valid_q[s_axis_tdata[13:6]];
            // Index 0 starts a new pattern: every table entry but the one for its byte reads as zero.
            if (s_axis_tdata[5:0] == '0) begin
              valid_d = '0;
            end else begin
              state_d = cksm_pkg::S_PRMW;
            end
            valid_d[s_axis_tdata[13:6]] = 1'b1;
          end else begin
            eot_d   = s_axis_tlast;
            wend_d  = wp_q;
            wp_d    = wp_q + PTR_W'(1);
            close_d = close_now;
            hit_d   = 1'b0;
            j_d     = '0;
            e_d     = '0;
            d_d     = init_vec;
            state_d = close_now ? cksm_pkg::S_FTXT : cksm_pkg::S_FIN;
          end
        end
      end
      cksm_pkg::S_PRMW: state_d = cksm_pkg::S_IDLE;
      cksm_pkg::S_FTXT: state_d = cksm_pkg::S_FTBL;
      cksm_pkg::S_FTBL: begin
        vbit_d  = valid_q[txt_rdata];
        state_d = cksm_pkg::S_FUPD;
      end
      cksm_pkg::S_FUPD: begin
        j_d = j_n;
        e_d = e_n;
        d_d = (d_sh == '0) ? init_vec : d_sh;
        if ((e_n <= kp1) && (j_n < m_len)) begin
          state_d = cksm_pkg::S_FTXT;
        end else if ((j_n == m_len) && (e_n <= kp1)) begin
          r_d = '0; t_d = '0; p_d = '0; diff_d = '0;
          state_d = cksm_pkg::S_VRD;
        end else begin
          state_d = cksm_pkg::S_FIN;
        end
      end
      cksm_pkg::S_VRD: state_d = cksm_pkg::S_VCMP;
      cksm_pkg::S_VCMP: begin
        state_d = cksm_pkg::S_VRD;
        if (diff_n > {1'b0, lim_q}) begin
          // Too many mismatches: move on to the next rotation, or finish after the last one.
          if (r_q == m_len - LEN_W'(1)) begin
            state_d = cksm_pkg::S_FIN;
          end else begin
            r_d = r_q + LEN_W'(1);
            p_d = r_q + LEN_W'(1);
            t_d = '0;
            diff_d = '0;
          end
        end else if (t_q == m_len - LEN_W'(1)) begin
          hit_d   = 1'b1;
          state_d = cksm_pkg::S_FIN;
        end else begin
          t_d    = t_q + LEN_W'(1);
          p_d    = (p_q == m_len - LEN_W'(1)) ? '0 : p_q + LEN_W'(1);
          diff_d = diff_n;
        end
      end
      cksm_pkg::S_FIN: begin
        if (!res_need || slot_free) begin
          if (res_need) begin
            out_valid_d = 1'b1;
            out_start_d = hit_q ? nws_q : '0;
            out_match_d = hit_q;
            out_cnt_d   = cnt_n;
            out_done_d  = eot_q;
          end
          if (eot_q) begin
            tpos_d = '0; nws_d = '0; total_d = '0;
          end else begin
            tpos_d  = tpos_q + POS_W'(1);
            total_d = cnt_n;
            if (close_q) begin
              nws_d = nws_q + POS_W'(m_len) - POS_W'(j_q) + POS_W'(1);
            end
          end
          state_d = cksm_pkg::S_IDLE;
        end
      end
      default: state_d = cksm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cksm_pkg::S_IDLE;
      len_q       <= LEN_W'(1);
      lim_q       <= '0;
      wp_q        <= '0;
      tpos_q      <= '0;
      nws_q       <= '0;
      total_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      eot_q       <= 1'b0;
      close_q     <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      lim_q       <= lim_d;
      wp_q        <= wp_d;
      tpos_q      <= tpos_d;
      nws_q       <= nws_d;
      total_q     <= total_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      eot_q       <= eot_d;
      close_q     <= close_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wend_q      <= wend_d;
    byte_q      <= byte_d;
    pidx_q      <= pidx_d;
    vbit_q      <= vbit_d;
    j_q         <= j_d;
    r_q         <= r_d;
    t_q         <= t_d;
    p_q         <= p_d;
    e_q         <= e_d;
    diff_q      <= diff_d;
    d_q         <= d_d;
    out_start_q <= out_start_d;
    out_cnt_q   <= out_cnt_d;
    out_match_q <= out_match_d;
    out_done_q  <= out_done_d;
  end

`include "circular_kmismatch_sbndm_matcher_assert.svh"

  // A text byte always leaves idle for the filter or the result step.
  `CKSM_ASSERT_NEXT(a_text_leaves_idle, in_acc && (s_axis_tuser == cksm_pkg::REQ_TEXT), state_q != cksm_pkg::S_IDLE)
  // The filter never scans more bytes than the window holds.
  `CKSM_ASSERT_SAME(a_filter_in_window, state_q == cksm_pkg::S_FUPD, j_q < m_len)
  // A rotation under comparison has never gone past the mismatch limit.
  `CKSM_ASSERT_SAME(a_diff_bounded, state_q == cksm_pkg::S_VCMP, diff_q <= {1'b0, lim_q})
  // A match is only reported for a byte that closed a window.
  `CKSM_ASSERT_SAME(a_hit_needs_close, (state_q == cksm_pkg::S_FIN) && hit_q, close_q)

endmodule

`default_nettype wire

/* test/circular_kmismatch_sbndm_matcher_test.sv */
// ----------------------------------------------------------------------------
// circular_kmismatch_sbndm_matcher_test
// Self-checking bench for the circular k-mismatch matcher. Pattern and text
// items are streamed in under random gaps, and a cycle-free predictor of the
// filter and rotation check supplies the expected match and end-of-text
// results. Results are compared field by field as they leave the block.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_kmismatch_sbndm_matcher_test;

  // Longest time the block can stay busy on one item: the filter scan plus a
  // full rotation check at the largest pattern length.
  localparam int BUSY_CYCLES = 8200;
  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [31:0] window_start;
    logic        matched;
    logic [31:0] occurrence_count;
    logic        text_done;
  } match_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [5:0]  cfg_data_i = '0;

  circular_kmismatch_sbndm_matcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: a copy of everything the block remembers.
  logic [7:0]  pat_mem [cksm_pkg::PAT_DEPTH];
  logic [63:0] bit_table [cksm_pkg::TABLE_DEPTH];
  logic [7:0]  text_buf [cksm_pkg::WINDOW_DEPTH];
  logic [31:0] next_start;
  logic [31:0] text_pos;
  logic [31:0] found_total;
  logic [cksm_pkg::PTR_W-1:0] buf_ptr;
  logic [cksm_pkg::LEN_W-1:0] len_reg;
  logic [cksm_pkg::LEN_W-1:0] limit_reg;

  match_result_t pending_results[$];
  int  fail_count = 0;
  bit  sender_burst = 1'b0;
  bit  hold_request = 1'b0;
  logic holding = 1'b0;

  // Byte at offset t of the window that ends at the newest text byte.
  function automatic logic [7:0] window_byte(int t, int m);
    return text_buf[(int'(buf_ptr) + cksm_pkg::WINDOW_DEPTH - (m - 1 - t))
                    % cksm_pkg::WINDOW_DEPTH];
  endfunction

  // True if some rotation of the pattern is within k mismatches of the window.
  function automatic bit any_rotation_fits(int m, int k);
    int diff;
    for (int r = 0; r < m; r++) begin
      diff = 0;
      for (int t = 0; t < m; t++)
        if (window_byte(t, m) != pat_mem[(r + t) % m]) diff++;
      if (diff <= k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted item to the predictor and queues any result it causes.
  function automatic void predict_match(logic req, logic [5:0] idx, logic [7:0] byte_v,
                                        logic eot);
    int m, k, j, resets;
    logic [63:0] full_vec, vec;
    bit hit;
    logic [31:0] start;
    match_result_t res;
    hit = 1'b0;
    start = '0;
    if (req == cksm_pkg::REQ_PATTERN) begin
      if (idx == 0) foreach (bit_table[i]) bit_table[i] = '0;
      pat_mem[idx] = byte_v;
      bit_table[byte_v][idx] = 1'b1;
      return;
    end
    text_buf[buf_ptr] = byte_v;
    m = (len_reg == 0) ? 1 : int'(len_reg);
    k = int'(limit_reg);
    if (text_pos == 32'(next_start + 32'(m) - 32'd1)) begin
      full_vec = (m + 1 >= 64) ? '1 : ((64'd1 << (m + 1)) - 64'd1);
      vec = full_vec;
      resets = 0;
      j = 0;
      while (resets <= k + 1 && j < m) begin
        j++;
        vec = (vec >> 1) & bit_table[window_byte(m - j, m)];
        if (vec == 0) begin
          resets++;
          vec = full_vec;
        end
      end
      if (j == m && resets <= k + 1 && any_rotation_fits(m, k)) begin
        hit = 1'b1;
        start = next_start;
        if (found_total != 32'hFFFF_FFFF) found_total++;
      end
      next_start = next_start + 32'(m - j + 1);
    end
    buf_ptr = buf_ptr + 1'b1;
    if (hit || eot) begin
      res.window_start = start;
      res.matched = hit;
      res.occurrence_count = found_total;
      res.text_done = eot;
      pending_results.push_back(res);
    end
    if (eot) begin
      text_pos = '0;
      next_start = '0;
      found_total = '0;
    end else begin
      text_pos++;
    end
  endfunction

  // Sends one input item, keeping tvalid high across back-to-back items.
  // Whoever stops sending drops tvalid.
  task automatic send_item(logic req, logic [5:0] idx, logic [7:0] byte_v, logic eot);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {2'b00, byte_v, idx};
    s_axis_tlast <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_match(req, idx, byte_v, eot);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_register(logic [cksm_pkg::CFG_IDX_W-1:0] idx, logic [5:0] value);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (BUSY_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == cksm_pkg::REG_PATTERN_LENGTH) len_reg = value;
    else if (idx == cksm_pkg::REG_MISMATCH_LIMIT) limit_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(bit wide);
    return wide ? 8'($urandom_range(0, 255)) : 8'(8'h61 + $urandom_range(0, 3));
  endfunction

  task automatic load_pattern(int m, bit wide);
    for (int i = 0; i < m; i++)
      send_item(cksm_pkg::REQ_PATTERN, 6'(i), pick_byte(wide), 1'($urandom));
  endtask

  // A text built mostly from rotations of the pattern with a few mutations, so
  // that windows survive the filter; noisy texts are random bytes.
  task automatic send_text(int len, bit noisy, bit wide);
    int m, offs;
    logic [7:0] b;
    m = (len_reg == 0) ? 1 : int'(len_reg);
    offs = $urandom_range(0, m - 1);
    for (int i = 0; i < len; i++) begin
      if (noisy || $urandom_range(0, 7) == 0) b = pick_byte(wide);
      else b = pat_mem[(offs + i) % m];
      if ($urandom_range(0, 30) == 0) offs = $urandom_range(0, m - 1);
      if (!noisy && $urandom_range(0, 60) == 0)
        send_item(cksm_pkg::REQ_PATTERN, 6'($urandom_range(1, m - 1 > 0 ? m - 1 : 0)),
                  pick_byte(wide), 1'b0);
      send_item(cksm_pkg::REQ_TEXT, 6'($urandom), b, i == len - 1);
    end
  endtask

  // Fills pattern entries 0 to 62 once so no later window reads an unwritten one.
  task automatic test_pattern_load();
    for (int i = 0; i < cksm_pkg::PAT_DEPTH - 1; i++)
      send_item(cksm_pkg::REQ_PATTERN, 6'(i), 8'($urandom), 1'b0);
  endtask

  task automatic test_directed();
    write_register(cksm_pkg::REG_PATTERN_LENGTH, 6'd0);  // zero length acts as one
    write_register(cksm_pkg::REG_MISMATCH_LIMIT, 6'd0);
    send_item(cksm_pkg::REQ_PATTERN, 6'd0, 8'hFF, 1'b1);
    send_item(cksm_pkg::REQ_TEXT, 6'd63, 8'h00, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'hFF, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'hFF, 1'b1);
    // Short text: fewer bytes than the pattern length closes no window.
    write_register(cksm_pkg::REG_PATTERN_LENGTH, 6'd4);
    send_item(cksm_pkg::REQ_PATTERN, 6'd0, 8'h10, 1'b0);
    send_item(cksm_pkg::REQ_PATTERN, 6'd1, 8'h20, 1'b0);
    send_item(cksm_pkg::REQ_PATTERN, 6'd2, 8'h30, 1'b0);
    send_item(cksm_pkg::REQ_PATTERN, 6'd3, 8'h40, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h30, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h40, 1'b1);
    // Exact rotation, then a rewritten index leaving a stale table bit.
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h30, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h40, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h10, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h20, 1'b0);
    send_item(cksm_pkg::REQ_PATTERN, 6'd2, 8'h00, 1'b1);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h00, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h40, 1'b0);
    send_item(cksm_pkg::REQ_TEXT, 6'd0, 8'h10, 1'b1);
    // Largest mismatch limit accepts any window that passes the filter.
    write_register(cksm_pkg::REG_MISMATCH_LIMIT, 6'd63);
    send_text(10, 1'b1, 1'b1);
  endtask

  task automatic test_random_phases();
    int lens[8] = '{1, 3, 5, 8, 2, 10, 6, 4};
    int lims[8] = '{0, 1, 63, 2, 0, 3, 1, 0};
    int sent;
    for (int p = 0; p < 8; p++) begin
      write_register(cksm_pkg::REG_PATTERN_LENGTH, 6'(lens[p]));
      write_register(cksm_pkg::REG_MISMATCH_LIMIT, 6'(lims[p]));
      sent = 0;
      while (sent < 180) begin
        int len;
        bit wide;
        wide = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) begin
          load_pattern(lens[p], wide);
          sent += lens[p];
        end
        len = $urandom_range(1, 40);
        sender_burst = ($urandom_range(0, 3) == 0);
        send_text(len, $urandom_range(0, 5) == 0, wide);
        sent += len;
      end
      sender_burst = 1'b0;
    end
  endtask

  task automatic test_longest_pattern();
    write_register(cksm_pkg::REG_PATTERN_LENGTH, 6'd63);
    write_register(cksm_pkg::REG_MISMATCH_LIMIT, 6'd5);
    load_pattern(63, 1'b0);
    send_text(75, 1'b0, 1'b0);
    send_text(20, 1'b0, 1'b0);
  endtask

  // The receiver holds off for a long stretch while matching text keeps
  // flowing, so the result register fills and the input backs up.
  task automatic test_output_backpressure();
    write_register(cksm_pkg::REG_PATTERN_LENGTH, 6'd3);
    write_register(cksm_pkg::REG_MISMATCH_LIMIT, 6'd1);
    load_pattern(3, 1'b0);
    hold_request = 1'b1;
    sender_burst = 1'b1;
    send_text(60, 1'b0, 1'b0);
    sender_burst = 1'b0;
  endtask

  // Long hold-off, counted here and applied by the receiver.
  initial begin
    forever begin
      wait (hold_request);
      @(posedge clk_i);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holding <= 1'b0;
      hold_request = 1'b0;
    end
  end

  // Result receiver and checker.
  int  stall_left = 0;
  bit  recv_burst = 1'b0;
  always @(posedge clk_i) begin
    match_result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: window_start %0d count %0d",
                 m_axis_tdata[31:0], m_axis_tdata[63:32]);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_res.window_start) begin
            $error("window_start expected %0d actual %0d",
                   exp_res.window_start, m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tuser !== exp_res.matched) begin
            $error("matched expected %0b actual %0b", exp_res.matched, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[63:32] !== exp_res.occurrence_count) begin
            $error("occurrence_count expected %0d actual %0d",
                   exp_res.occurrence_count, m_axis_tdata[63:32]);
            fail_count++;
          end
          if (m_axis_tlast !== exp_res.text_done) begin
            $error("text_done expected %0b actual %0b", exp_res.text_done, m_axis_tlast);
            fail_count++;
          end
        end
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 10);
      end
      if (holding || stall_left > 0) begin
        m_axis_tready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no channel has moved an item for too long.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[circular_kmismatch_sbndm_matcher] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (pat_mem[i]) pat_mem[i] = '0;
    foreach (bit_table[i]) bit_table[i] = '0;
    foreach (text_buf[i]) text_buf[i] = '0;
    next_start = '0;
    text_pos = '0;
    found_total = '0;
    buf_ptr = '0;
    len_reg = 6'd1;
    limit_reg = 6'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pattern_load();
    test_directed();
    test_random_phases();
    test_longest_pattern();
    test_output_backpressure();
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (BUSY_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[circular_kmismatch_sbndm_matcher] OK");
    end else begin
      $display("[circular_kmismatch_sbndm_matcher] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* circular_kmismatch_sbndm_matcher.f */
+incdir+design
design/cksm_pkg.sv
design/cksm_ram.sv
design/circular_kmismatch_sbndm_matcher.sv
test/circular_kmismatch_sbndm_matcher_test.sv
